### rtl/core/ipv6_route_table_lpm_defines.svh
// assertion macros for the route table
`ifndef IPV6_ROUTE_TABLE_LPM_DEFINES_SVH
`define IPV6_ROUTE_TABLE_LPM_DEFINES_SVH
`define RT_ASSERT_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define RT_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

### rtl/core/rtl_pkg.sv
package rtl_pkg;
	localparam int ENTRIES = 8;
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [7:0] MAX_PLEN = 8'd128;

	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_UPDATED = 3'd1;
	localparam logic [2:0] ST_EVICTED = 3'd2;
	localparam logic [2:0] ST_HIT = 3'd3;
	localparam logic [2:0] ST_MISS = 3'd4;
	localparam logic [2:0] ST_REMOVED = 3'd5;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_OUT} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic decide;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
	} stat_t;

	function automatic logic [127:0] pmask(input logic [7:0] len);
		logic [127:0] m;
		m = '0;
		for (int b = 0; b < 128; b++)
			m[127 - b] = (b < int'(len));
		return m;
	endfunction
endpackage

### rtl/core/rtl_ctrl.sv
module rtl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	output logic            ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  rtl_pkg::stat_t  stat,
	output rtl_pkg::cmd_t   cmd
);
	rtl_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rtl_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			rtl_pkg::S_IDLE: begin
				ready = 1'b1;
				if (valid) begin
					cmd.load = 1'b1;
					state_d = rtl_pkg::S_SCAN;
				end
			end
			rtl_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) state_d = rtl_pkg::S_DECIDE;
			end
			rtl_pkg::S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = rtl_pkg::S_OUT;
			end
			rtl_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = rtl_pkg::S_IDLE;
			end
			default: state_d = rtl_pkg::S_IDLE;
		endcase
	end
endmodule

### rtl/core/rtl_dp.sv
module rtl_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rtl_pkg::cmd_t         cmd,
	output rtl_pkg::stat_t        stat,
	input  logic [1:0]            req_type,
	input  logic [63:0]           addr_hi,
	input  logic [63:0]           addr_lo,
	input  logic [7:0]            prefix_len,
	input  logic [63:0]           hop_hi,
	input  logic [63:0]           hop_lo,
	input  logic [7:0]            route_cost,
	input  logic [31:0]           seq_number,
	input  logic [2:0]            slot_sel,
	output logic [2:0]            status,
	output logic [2:0]            slot_out,
	output logic [63:0]           dest_hi_out,
	output logic [63:0]           dest_lo_out,
	output logic [7:0]            len_out,
	output logic [63:0]           next_hi_out,
	output logic [63:0]           next_lo_out,
	output logic [7:0]            cost_out,
	output logic [31:0]           seq_out
);
	localparam int N = rtl_pkg::ENTRIES;
	localparam int IW = rtl_pkg::IW;

	logic [N-1:0]   vld_q;
	logic [127:0]   pfx_q [N];
	logic [7:0]     len_q [N];
	logic [127:0]   hop_q [N];
	logic [7:0]     cst_q [N];
	logic [31:0]    sq_q  [N];
	logic [IW-1:0]  age_q [N];

	// latched request
	logic [1:0]   req_q;
	logic [127:0] addr_q, hopr_q;
	logic [7:0]   plen_q, rc_q;
	logic [31:0]  sn_q;
	logic [2:0]   sel_q;
	logic [IW-1:0] idx_q;

	// scan results
	logic          dup_q, free_q, best_f_q;
	logic [IW-1:0] dup_i_q, free_i_q, old_i_q, best_i_q;
	logic [IW-1:0] old_a_q;

	logic [2:0]    st_q, so_q;
	logic          dat_q;
	logic [IW-1:0] di_q;

	logic [127:0] ent_p;
	logic [7:0]   ent_l;
	logic         ent_v, is_dup, is_hit, better;
	logic [127:0] madd;

	assign madd = addr_q & rtl_pkg::pmask(plen_q);
	assign ent_p = pfx_q[idx_q];
	assign ent_l = len_q[idx_q];
	assign ent_v = vld_q[idx_q];
	assign is_dup = ent_v && ent_l == plen_q && ent_p == madd && hop_q[idx_q] == hopr_q;
	assign is_hit = ent_v && ((addr_q & rtl_pkg::pmask(ent_l)) == ent_p);
	assign better = !best_f_q || ent_l > len_q[best_i_q] ||
		(ent_l == len_q[best_i_q] && (cst_q[idx_q] < cst_q[best_i_q] ||
		(cst_q[idx_q] == cst_q[best_i_q] && age_q[idx_q] < age_q[best_i_q])));
	assign stat.scan_last = (idx_q == IW'(N - 1));

	logic sel_ok;
	assign sel_ok = (32'(sel_q) < N) && vld_q[sel_q[IW-1:0]];

	logic [IW-1:0] wslot;
	assign wslot = free_q ? free_i_q : old_i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			for (int i = 0; i < N; i++) begin
				pfx_q[i] <= '0; len_q[i] <= '0; hop_q[i] <= '0;
				cst_q[i] <= '0; sq_q[i] <= '0; age_q[i] <= '0;
			end
		end else if (cmd.decide) begin
			case (req_q)
				rtl_pkg::REQ_ADD: begin
					if (dup_q) begin
						cst_q[dup_i_q] <= rc_q;
						sq_q[dup_i_q] <= sn_q;
					end else begin
						for (int i = 0; i < N; i++)
							if (vld_q[i] && IW'(i) != wslot && age_q[i] != IW'(N - 1))
								age_q[i] <= age_q[i] + 1'b1;
						vld_q[wslot] <= 1'b1;
						pfx_q[wslot] <= madd;
						len_q[wslot] <= plen_q;
						hop_q[wslot] <= hopr_q;
						cst_q[wslot] <= rc_q;
						sq_q[wslot] <= sn_q;
						age_q[wslot] <= '0;
					end
				end
				rtl_pkg::REQ_REMOVE: begin
					if (sel_ok) begin
						vld_q[sel_q[IW-1:0]] <= 1'b0;
						age_q[sel_q[IW-1:0]] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			addr_q <= {addr_hi, addr_lo};
			hopr_q <= {hop_hi, hop_lo};
			plen_q <= (prefix_len > rtl_pkg::MAX_PLEN) ? rtl_pkg::MAX_PLEN : prefix_len;
			rc_q <= route_cost;
			sn_q <= seq_number;
			sel_q <= slot_sel;
			idx_q <= '0;
			dup_q <= 1'b0; free_q <= 1'b0; best_f_q <= 1'b0;
			dup_i_q <= '0; free_i_q <= '0; old_i_q <= '0; best_i_q <= '0;
			old_a_q <= '0;
		end
		if (cmd.scan) begin
			idx_q <= idx_q + 1'b1;
			if (is_dup && !dup_q) begin
				dup_q <= 1'b1; dup_i_q <= idx_q;
			end
			if (!ent_v && !free_q) begin
				free_q <= 1'b1; free_i_q <= idx_q;
			end
			if (age_q[idx_q] > old_a_q) begin
				old_a_q <= age_q[idx_q]; old_i_q <= idx_q;
			end
			if (is_hit && better) begin
				best_f_q <= 1'b1; best_i_q <= idx_q;
			end
		end
		if (cmd.decide) begin
			dat_q <= 1'b0;
			st_q <= rtl_pkg::ST_MISS;
			so_q <= '0;
			di_q <= '0;
			case (req_q)
				rtl_pkg::REQ_ADD: begin
					dat_q <= 1'b1;
					if (dup_q) begin
						st_q <= rtl_pkg::ST_UPDATED; so_q <= 3'(dup_i_q); di_q <= dup_i_q;
					end else begin
						st_q <= free_q ? rtl_pkg::ST_INSERTED : rtl_pkg::ST_EVICTED;
						so_q <= 3'(wslot); di_q <= wslot;
					end
				end
				rtl_pkg::REQ_LOOKUP: begin
					if (best_f_q) begin
						st_q <= rtl_pkg::ST_HIT; so_q <= 3'(best_i_q);
						di_q <= best_i_q; dat_q <= 1'b1;
					end
				end
				rtl_pkg::REQ_REMOVE: begin
					st_q <= rtl_pkg::ST_REMOVED; so_q <= sel_q;
					di_q <= sel_q[IW-1:0];
					dat_q <= sel_ok;
				end
				default: ;
			endcase
		end
	end

	// table already holds the post-decide entry, which is what gets reported
	assign status = st_q;
	assign slot_out = so_q;
	assign dest_hi_out = dat_q ? pfx_q[di_q][127:64] : '0;
	assign dest_lo_out = dat_q ? pfx_q[di_q][63:0] : '0;
	assign len_out = dat_q ? len_q[di_q] : '0;
	assign next_hi_out = dat_q ? hop_q[di_q][127:64] : '0;
	assign next_lo_out = dat_q ? hop_q[di_q][63:0] : '0;
	assign cost_out = dat_q ? cst_q[di_q] : '0;
	assign seq_out = dat_q ? sq_q[di_q] : '0;
endmodule

### rtl/core/ipv6_route_table_lpm.sv
// channel   handshake              payload
// request   valid / ready          req_type .. slot_sel
// result    out_valid / out_ready  status .. seq_out
// one request is taken at a time: load, a scan of every slot, decide, result
// (the result is then held until out_ready)
// the scan reads one slot per cycle through a single shared compare unit
// reset clears the whole table at once; a stalled result blocks new requests
`include "ipv6_route_table_lpm_defines.svh"
module ipv6_route_table_lpm (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  req_type,
	input  logic [63:0] addr_hi,
	input  logic [63:0] addr_lo,
	input  logic [7:0]  prefix_len,
	input  logic [63:0] hop_hi,
	input  logic [63:0] hop_lo,
	input  logic [7:0]  route_cost,
	input  logic [31:0] seq_number,
	input  logic [2:0]  slot_sel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [2:0]  slot_out,
	output logic [63:0] dest_hi_out,
	output logic [63:0] dest_lo_out,
	output logic [7:0]  len_out,
	output logic [63:0] next_hi_out,
	output logic [63:0] next_lo_out,
	output logic [7:0]  cost_out,
	output logic [31:0] seq_out
);
	rtl_pkg::cmd_t  cmd;
	rtl_pkg::stat_t stat;

	rtl_ctrl u_ctrl (.clk, .arst_n, .valid, .ready, .out_valid, .out_ready, .stat, .cmd);

	rtl_dp u_dp (.clk, .arst_n, .cmd, .stat, .req_type, .addr_hi, .addr_lo, .prefix_len,
		.hop_hi, .hop_lo, .route_cost, .seq_number, .slot_sel, .status, .slot_out,
		.dest_hi_out, .dest_lo_out, .len_out, .next_hi_out, .next_lo_out, .cost_out,
		.seq_out);

	`RT_ASSERT_IMP(a_no_overlap, out_valid, !ready)
	`RT_ASSERT_NEXT(a_load_scan, valid && ready, !ready && !out_valid)
	`RT_ASSERT_IMP(a_status_range, out_valid, status <= rtl_pkg::ST_REMOVED)
endmodule
